@@ hdl/sm4_pkg.sv @@
// Shared constants and functions for the SM4 block cipher.
// Holds the S-box, the system constants FK and the round constant generator.
// No dependencies; used by sm4_round and sm4_block_cipher_top.
package sm4_pkg;

    localparam int ROUNDS = 32;
    localparam int ROUND_W = 5;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW = 2'd1;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // Byte j of round constant i is 7 * (4i + j) modulo 256.
    function automatic logic [31:0] round_const(input logic [ROUND_W-1:0] idx);
        logic [7:0] base;
        base = 8'({1'b0, idx, 2'b00} * 8'd7);
        return {base, 8'(base + 8'd7), 8'(base + 8'd14), 8'(base + 8'd21)};
    endfunction

endpackage

@@ hdl/sm4_round.sv @@
// Shared SM4 round function: byte-wise S-box followed by a linear map.
// Selects the data map L or the key schedule map L'.
// Depends on sm4_pkg.
module sm4_round
(
    input  logic        key_mode,
    input  logic [31:0] data_in,
    output logic [31:0] data_out
);

    logic [31:0] s;
    logic [31:0] lin_data;
    logic [31:0] lin_key;

    assign s = sm4_pkg::sub_word(data_in);

    assign lin_data = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
                    ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
    assign lin_key  = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};

    assign data_out = key_mode ? lin_key : lin_data;

endmodule

@@ hdl/sm4_block_cipher_top.sv @@
// SM4 block cipher top level with key schedule sequencer and round key store.
// Depends on sm4_pkg and sm4_round.
//
// Usage:
// The key is written through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data): index 0 holds key words 0 and 1, index 1 holds key
// words 2 and 3. Other indexes are ignored. Every key write starts a key
// expansion, during which in_ready stays low. While a key write is offered,
// in_ready is also held low so that the write goes first.
// A block is a transfer on the input channel (in_valid, in_ready) with the
// operation bit req_type (0 encrypt, 1 decrypt) and four 32-bit words.
// One shared round unit runs one round per cycle while it is not stalled, and
// the result is registered for the output channel (out_valid, out_ready)
// after the last round. A new block is taken only in idle, once the previous
// result is registered, so only one block is in the rounds at a time.
// The result waits in an output register; a new block may be accepted while
// it waits. If the receiver still stalls when the next block finishes, the
// last round holds until the output register is free.
// Reset clears the key to zero and runs the key expansion for it.
module sm4_block_cipher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [31:0] in_word0,
    input  logic [31:0] in_word1,
    input  logic [31:0] in_word2,
    input  logic [31:0] in_word3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word0,
    output logic [31:0] out_word1,
    output logic [31:0] out_word2,
    output logic [31:0] out_word3
);

    typedef enum logic [1:0] {ST_LOAD, ST_KEYEXP, ST_IDLE, ST_RUN} state_t;

    localparam logic [sm4_pkg::ROUND_W-1:0] LAST_ROUND =
        sm4_pkg::ROUND_W'(sm4_pkg::ROUNDS - 1);

    state_t                        state_reg;
    logic [sm4_pkg::ROUND_W-1:0]   cnt_reg;
    logic                          dec_reg;
    logic [31:0]                   w_reg [4];
    logic [63:0]                   key_high_reg;
    logic [63:0]                   key_low_reg;
    logic                          out_valid_reg;
    logic [31:0]                   out_word0_reg;
    logic [31:0]                   out_word1_reg;
    logic [31:0]                   out_word2_reg;
    logic [31:0]                   out_word3_reg;

    logic [31:0]                   rk_mem [sm4_pkg::ROUNDS];
    logic [31:0]                   rk_reg;
    logic [sm4_pkg::ROUND_W-1:0]   rd_addr;
    logic [sm4_pkg::ROUND_W-1:0]   cnt_inc;
    logic                          rk_load;

    logic        key_mode;
    logic [31:0] round_in;
    logic [31:0] round_out;
    logic [31:0] new_word;
    logic        last_round;
    logic        run_advance;
    logic        block_done;
    logic        in_xfer;
    logic        cfg_xfer;
    logic        cfg_write;

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg != ST_RUN);
    assign out_valid = out_valid_reg;
    assign out_word0 = out_word0_reg;
    assign out_word1 = out_word1_reg;
    assign out_word2 = out_word2_reg;
    assign out_word3 = out_word3_reg;

    assign in_xfer   = in_valid && in_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_write = cfg_xfer && ((cfg_index == sm4_pkg::CFG_KEY_HIGH)
                                 || (cfg_index == sm4_pkg::CFG_KEY_LOW));

    assign key_mode    = (state_reg == ST_KEYEXP);
    assign last_round  = (cnt_reg == LAST_ROUND);
    assign run_advance = !last_round || !out_valid_reg || out_ready;
    assign block_done  = (state_reg == ST_RUN) && last_round && run_advance;

    assign round_in = w_reg[1] ^ w_reg[2] ^ w_reg[3]
                    ^ (key_mode ? sm4_pkg::round_const(cnt_reg) : rk_reg);
    assign new_word = w_reg[0] ^ round_out;

    sm4_round u_round
    (
        .key_mode (key_mode),
        .data_in  (round_in),
        .data_out (round_out)
    );

    assign cnt_inc = cnt_reg + 1'b1;
    assign rk_load = (state_reg == ST_IDLE) || ((state_reg == ST_RUN) && run_advance);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = req_type ? LAST_ROUND : '0;
        end
        else
        begin
            rd_addr = dec_reg ? ~cnt_inc : cnt_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KEYEXP)
        begin
            rk_mem[cnt_reg] <= new_word;
        end
        if (rk_load)
        begin
            rk_reg <= rk_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            dec_reg       <= 1'b0;
            w_reg         <= '{default: '0};
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word0_reg <= '0;
            out_word1_reg <= '0;
            out_word2_reg <= '0;
            out_word3_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !block_done)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_xfer && (cfg_index == sm4_pkg::CFG_KEY_HIGH))
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_xfer && (cfg_index == sm4_pkg::CFG_KEY_LOW))
            begin
                key_low_reg <= cfg_data;
            end

            // A key write restarts the schedule with the updated key.
            if (cfg_write)
            begin
                cnt_reg   <= '0;
                state_reg <= ST_LOAD;
            end
            else
            begin
                unique case (state_reg)
                    ST_LOAD:
                    begin
                        w_reg[0]  <= key_high_reg[63:32] ^ sm4_pkg::FK0;
                        w_reg[1]  <= key_high_reg[31:0] ^ sm4_pkg::FK1;
                        w_reg[2]  <= key_low_reg[63:32] ^ sm4_pkg::FK2;
                        w_reg[3]  <= key_low_reg[31:0] ^ sm4_pkg::FK3;
                        cnt_reg   <= '0;
                        state_reg <= ST_KEYEXP;
                    end
                    ST_KEYEXP:
                    begin
                        w_reg     <= '{w_reg[1], w_reg[2], w_reg[3], new_word};
                        cnt_reg   <= cnt_inc;
                        if (last_round)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (in_xfer)
                        begin
                            w_reg     <= '{in_word0, in_word1, in_word2, in_word3};
                            dec_reg   <= req_type;
                            cnt_reg   <= '0;
                            state_reg <= ST_RUN;
                        end
                    end
                    ST_RUN:
                    begin
                        if (run_advance)
                        begin
                            w_reg   <= '{w_reg[1], w_reg[2], w_reg[3], new_word};
                            cnt_reg <= cnt_inc;
                            if (last_round)
                            begin
                                out_word0_reg <= new_word;
                                out_word1_reg <= w_reg[3];
                                out_word2_reg <= w_reg[2];
                                out_word3_reg <= w_reg[1];
                                out_valid_reg <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_LOAD;
                    end
                endcase
            end
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RUN) && (cnt_reg == '0) && !in_ready)
        else $error("input transfer did not start a block");

    assert property (@(posedge clk) disable iff (!rst_n)
        block_done |=> out_valid_reg && (state_reg == ST_IDLE) && (cnt_reg == '0))
        else $error("final round did not register a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result appeared without a running block");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && !run_advance) |=> $stable(cnt_reg) && $stable(rk_reg))
        else $error("stalled final round moved on");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (state_reg == ST_LOAD) && !in_ready)
        else $error("key write did not restart the key schedule");
`endif

endmodule

@@ test/sm4_result_checker.sv @@
// Result checker for the SM4 block cipher: watches the key, input and output channels.
// Keeps its own copy of the key and round keys, predicts each block and compares the results.
// Depends on sm4_pkg for the S-box, the FK constants and the register indexes.
module sm4_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        req_type,
    input  logic [31:0] in_word0,
    input  logic [31:0] in_word1,
    input  logic [31:0] in_word2,
    input  logic [31:0] in_word3,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_word0,
    input  logic [31:0] out_word1,
    input  logic [31:0] out_word2,
    input  logic [31:0] out_word3,
    output int          blocks_in,
    output int          blocks_out,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } sm4_block_t;

    logic [63:0] key_high_q;
    logic [63:0] key_low_q;
    logic [31:0] round_key [sm4_pkg::ROUNDS];
    sm4_block_t  expected_blocks [$];

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] v);
        logic [31:0] r;
        for (int b = 0; b < 4; b++)
        begin
            r[8*b +: 8] = sm4_pkg::SBOX[v[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] ck;
        logic [31:0] t;
        k[0] = key_high_q[63:32] ^ sm4_pkg::FK0;
        k[1] = key_high_q[31:0] ^ sm4_pkg::FK1;
        k[2] = key_low_q[63:32] ^ sm4_pkg::FK2;
        k[3] = key_low_q[31:0] ^ sm4_pkg::FK3;
        for (int i = 0; i < sm4_pkg::ROUNDS; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ck[31 - 8*j -: 8] = 8'((4*i + j) * 7);
            end
            t = sbox_word(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck);
            k[i % 4] = k[i % 4] ^ t ^ rotl32(t, 13) ^ rotl32(t, 23);
            round_key[i] = k[i % 4];
        end
    endfunction

    function automatic sm4_block_t sm4_crypt_block(input logic decrypt, input sm4_block_t blk);
        logic [31:0] x [4];
        logic [31:0] t;
        sm4_block_t r;
        x[0] = blk.w0;
        x[1] = blk.w1;
        x[2] = blk.w2;
        x[3] = blk.w3;
        for (int i = 0; i < sm4_pkg::ROUNDS; i++)
        begin
            t = x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4]
                ^ (decrypt ? round_key[sm4_pkg::ROUNDS - 1 - i] : round_key[i]);
            t = sbox_word(t);
            x[i % 4] = x[i % 4] ^ t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18)
                       ^ rotl32(t, 24);
        end
        r.w0 = x[3];
        r.w1 = x[2];
        r.w2 = x[1];
        r.w3 = x[0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
        begin
            $display("ERROR: result %0d, %s: got %08h, expected %08h",
                     blocks_out, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sm4_block_t blk;
        sm4_block_t got;
        sm4_block_t want;
        if (!rst_n)
        begin
            key_high_q = '0;
            key_low_q = '0;
            expand_round_keys();
            expected_blocks.delete();
            blocks_in <= 0;
            blocks_out <= 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sm4_pkg::CFG_KEY_HIGH)
                begin
                    key_high_q = cfg_data;
                    expand_round_keys();
                end
                else if (cfg_index == sm4_pkg::CFG_KEY_LOW)
                begin
                    key_low_q = cfg_data;
                    expand_round_keys();
                end
            end
            if (in_valid && in_ready)
            begin
                blk.w0 = in_word0;
                blk.w1 = in_word1;
                blk.w2 = in_word2;
                blk.w3 = in_word3;
                expected_blocks.push_back(sm4_crypt_block(req_type, blk));
                blocks_in <= blocks_in + 1;
            end
            if (out_valid && out_ready)
            begin
                got.w0 = out_word0;
                got.w1 = out_word1;
                got.w2 = out_word2;
                got.w3 = out_word3;
                if (expected_blocks.size() == 0)
                begin
                    report_mismatch("result with no block pending, out_word0", got.w0, '0);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (got.w0 !== want.w0) report_mismatch("out_word0", got.w0, want.w0);
                    if (got.w1 !== want.w1) report_mismatch("out_word1", got.w1, want.w1);
                    if (got.w2 !== want.w2) report_mismatch("out_word2", got.w2, want.w2);
                    if (got.w3 !== want.w3) report_mismatch("out_word3", got.w3, want.w3);
                end
                blocks_out <= blocks_out + 1;
            end
        end
    end

endmodule

@@ test/tb_top.sv @@
// Top level of the SM4 block cipher testbench: clock, reset, key writes and block stimulus.
// Instantiates sm4_block_cipher_top and sm4_result_checker, which checks the results.
// Depends on sm4_pkg for the key register indexes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BLOCKS = 1600;
    localparam int PHASES = 8;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;
    localparam logic [1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [1:0] CFG_UNUSED_3 = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [31:0] in_word0 = '0;
    logic [31:0] in_word1 = '0;
    logic [31:0] in_word2 = '0;
    logic [31:0] in_word3 = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;

    int blocks_in;
    int blocks_out;
    int mismatches;
    int cycle_count = 0;
    int n_encrypt = 0;
    int n_decrypt = 0;
    int n_key_writes = 0;
    logic sink_steady = 1'b0;
    int sink_left = 0;

    sm4_block_cipher_top dut (.*);

    sm4_result_checker result_check (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            if (sink_steady || !out_ready)
            begin
                out_ready <= 1'b1;
                sink_left <= $urandom_range(1, 40);
            end
            else
            begin
                out_ready <= 1'b0;
                sink_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                         : $urandom_range(1, 8);
            end
        end
        else
        begin
            sink_left <= sink_left - 1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_block(input logic op, input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2, input logic [31:0] w3);
        in_valid <= 1'b1;
        req_type <= op;
        in_word0 <= w0;
        in_word1 <= w1;
        in_word2 <= w2;
        in_word3 <= w3;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op == OP_DECRYPT) n_decrypt++;
        else n_encrypt++;
    endtask

    task automatic pause_input(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (blocks_in != blocks_out);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_key_writes++;
    endtask

    task automatic send_random_block();
        send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    initial
    begin : stimulus
        int burst_left;
        int per_phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_block(OP_ENCRYPT, '0, '0, '0, '0);
        pause_input($urandom_range(1, 40));
        send_block(OP_ENCRYPT, '1, '1, '1, '1);
        send_block(OP_DECRYPT, '0, '0, '0, '0);
        pause_input($urandom_range(1, 40));
        send_block(OP_DECRYPT, '1, '1, '1, '1);
        wait_drained();

        write_reg(sm4_pkg::CFG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(sm4_pkg::CFG_KEY_LOW, 64'hfedcba9876543210);
        send_block(OP_ENCRYPT, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
        send_block(OP_DECRYPT, 32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246);
        pause_input($urandom_range(1, 40));
        send_block(OP_ENCRYPT, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
        send_block(OP_DECRYPT, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
        wait_drained();

        write_reg(sm4_pkg::CFG_KEY_LOW, '1);
        send_block(OP_ENCRYPT, '1, '1, '1, '1);
        send_block(OP_DECRYPT, '0, '0, '0, '0);
        wait_drained();

        write_reg(CFG_UNUSED_2, '1);
        write_reg(CFG_UNUSED_3, {$urandom(), $urandom()});
        send_block(OP_ENCRYPT, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
        send_block(OP_DECRYPT, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
        wait_drained();

        write_reg(sm4_pkg::CFG_KEY_HIGH, '1);
        send_block(OP_ENCRYPT, '0, '0, '0, '0);
        send_block(OP_ENCRYPT, '1, '1, '1, '1);
        send_block(OP_DECRYPT, '1, '1, '1, '1);
        repeat (4) send_random_block();
        wait_drained();

        per_phase = RANDOM_BLOCKS / PHASES;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            sink_steady <= (phase % 4 == 1);
            case (phase)
                1:
                begin
                    write_reg(sm4_pkg::CFG_KEY_HIGH, '1);
                    write_reg(sm4_pkg::CFG_KEY_LOW, '1);
                end
                2: write_reg(sm4_pkg::CFG_KEY_LOW, pick_key());
                3:
                begin
                    write_reg(CFG_UNUSED_3, {$urandom(), $urandom()});
                    write_reg(sm4_pkg::CFG_KEY_HIGH, pick_key());
                end
                5:
                begin
                    write_reg(sm4_pkg::CFG_KEY_HIGH, '0);
                    write_reg(sm4_pkg::CFG_KEY_LOW, '0);
                end
                6:
                begin
                    write_reg(CFG_UNUSED_2, {$urandom(), $urandom()});
                    write_reg(sm4_pkg::CFG_KEY_HIGH, {$urandom(), $urandom()});
                end
                default:
                begin
                    write_reg(sm4_pkg::CFG_KEY_HIGH, {$urandom(), $urandom()});
                    write_reg(sm4_pkg::CFG_KEY_LOW, {$urandom(), $urandom()});
                end
            endcase
            burst_left = $urandom_range(1, 12);
            for (int n = 0; n < per_phase; n++)
            begin
                send_random_block();
                if (phase != 2)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        pause_input(($urandom_range(0, 4) == 0) ? $urandom_range(20, 45)
                                                                : $urandom_range(1, 6));
                        burst_left = $urandom_range(1, 12);
                    end
                    else if ($urandom_range(0, 99) == 0)
                    begin
                        wait_drained();
                    end
                end
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        $display("Summary: %0d blocks checked (%0d encrypt, %0d decrypt), %0d key writes, %0d cycles.",
                 blocks_out, n_encrypt, n_decrypt, n_key_writes, cycle_count);
        $display("Covered zero, all-ones and random keys and blocks, single-word key updates,");
        $display("ignored register indexes, input gaps and output back-pressure.");
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
